/* src/bim_pkg.sv */
`default_nettype none
package bim_pkg;

  localparam int MAX_AXES    = 4;
  localparam int DIM_BITS    = 16;
  localparam int IDX_BITS    = 32;
  localparam int OFF_BITS    = 34;
  localparam int REG_BITS    = 64;
  localparam int RANK_BITS   = 3;
  localparam int PROD_BITS   = 2 * DIM_BITS;
  localparam int RADIX_STEPS = 4;
  localparam int DIV_STAGES  = IDX_BITS / RADIX_STEPS;

  typedef enum logic [2:0] {
    CFG_LEFT_RANK   = 3'd0,
    CFG_RIGHT_RANK  = 3'd1,
    CFG_LEFT_SIZES  = 3'd2,
    CFG_RIGHT_SIZES = 3'd3,
    CFG_LEFT_STEPS  = 3'd4,
    CFG_RIGHT_STEPS = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHAPE = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // decoded shape; the user keeps it stable while items are in flight, the block does not enforce it
  typedef struct packed {
    logic [MAX_AXES-1:0][DIM_BITS-1:0] divisor;
    logic [MAX_AXES-1:0][DIM_BITS-1:0] step_l;
    logic [MAX_AXES-1:0][DIM_BITS-1:0] step_r;
    logic                              bad;
    logic                              empty;
  } shape_t;

  // per-item state carried down the pipe
  typedef struct packed {
    logic [DIM_BITS-1:0]  rem;
    logic [IDX_BITS-1:0]  quo;
    logic [PROD_BITS-1:0] prod_l;
    logic [PROD_BITS-1:0] prod_r;
    logic [OFF_BITS-1:0]  acc_l;
    logic [OFF_BITS-1:0]  acc_r;
  } pipe_t;

  function automatic logic [DIM_BITS-1:0] field_of(input logic [REG_BITS-1:0] r,
                                                   input int k);
    logic [DIM_BITS-1:0] f;
    int pos;
    f = '0;
    for (int j = 0; j < DIM_BITS; j++) begin
      pos = k * DIM_BITS + j;
      if (pos < REG_BITS) begin
        f[j] = r[pos[5:0]];
      end
    end
    return f;
  endfunction

endpackage
`default_nettype wire

/* src/bim_cfg.sv */
`default_nettype none
module bim_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [2:0]                    wr_index,
  input  wire logic [bim_pkg::REG_BITS-1:0]  wr_data,
  output bim_pkg::shape_t                    shape
);

  logic [bim_pkg::RANK_BITS-1:0] lrank_r, rrank_r;
  logic [bim_pkg::REG_BITS-1:0]  lsize_r, rsize_r, lstep_r, rstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrank_r <= '0;
      rrank_r <= '0;
      lsize_r <= '0;
      rsize_r <= '0;
      lstep_r <= '0;
      rstep_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        bim_pkg::CFG_LEFT_RANK:   lrank_r <= wr_data[bim_pkg::RANK_BITS-1:0];
        bim_pkg::CFG_RIGHT_RANK:  rrank_r <= wr_data[bim_pkg::RANK_BITS-1:0];
        bim_pkg::CFG_LEFT_SIZES:  lsize_r <= wr_data;
        bim_pkg::CFG_RIGHT_SIZES: rsize_r <= wr_data;
        bim_pkg::CFG_LEFT_STEPS:  lstep_r <= wr_data;
        bim_pkg::CFG_RIGHT_STEPS: rstep_r <= wr_data;
        default: ;
      endcase
    end
  end

  localparam logic [bim_pkg::DIM_BITS-1:0] ONE = bim_pkg::DIM_BITS'(1);

  always_comb begin
    logic [bim_pkg::DIM_BITS-1:0] da, db, dr;
    shape = '0;
    for (int k = 0; k < bim_pkg::MAX_AXES; k++) begin
      da = (k < int'(lrank_r)) ? bim_pkg::field_of(lsize_r, k) : ONE;
      db = (k < int'(rrank_r)) ? bim_pkg::field_of(rsize_r, k) : ONE;
      shape.step_l[k] = (k < int'(lrank_r) && da != ONE) ? bim_pkg::field_of(lstep_r, k) : '0;
      shape.step_r[k] = (k < int'(rrank_r) && db != ONE) ? bim_pkg::field_of(rstep_r, k) : '0;
      if (da != ONE && db != ONE && da != db) begin
        shape.bad = 1'b1;
      end
      dr = (da > db) ? da : db;
      // empty axis divides by one: coordinate zero, index unchanged
      if (dr == '0) begin
        shape.empty = 1'b1;
        shape.divisor[k] = ONE;
      end else begin
        shape.divisor[k] = dr;
      end
    end
  end

endmodule
`default_nettype wire

/* src/bim_div_stage.sv */
`default_nettype none
module bim_div_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          in_v,
  input  wire bim_pkg::pipe_t                in_d,
  input  wire logic [bim_pkg::DIM_BITS-1:0]  divisor,
  output logic                               out_v,
  output bim_pkg::pipe_t                     out_d
);

  bim_pkg::pipe_t d_nxt, d_r;
  logic           v_r;

  // restoring division, RADIX_STEPS (4) quotient bits per stage
  always_comb begin
    logic [bim_pkg::DIM_BITS:0]   t;
    logic [bim_pkg::DIM_BITS-1:0] r;
    logic [bim_pkg::IDX_BITS-1:0] q;
    d_nxt = in_d;
    r = in_d.rem;
    q = in_d.quo;
    for (int i = 0; i < bim_pkg::RADIX_STEPS; i++) begin
      t = {r, q[bim_pkg::IDX_BITS-1]};
      q = {q[bim_pkg::IDX_BITS-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[bim_pkg::DIM_BITS-1:0];
    end
    d_nxt.rem = r;
    d_nxt.quo = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule
`default_nettype wire

/* src/bim_mac_stage.sv */
`default_nettype none
module bim_mac_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          in_v,
  input  wire bim_pkg::pipe_t                in_d,
  input  wire logic [bim_pkg::DIM_BITS-1:0]  step_l,
  input  wire logic [bim_pkg::DIM_BITS-1:0]  step_r,
  output logic                               out_v,
  output bim_pkg::pipe_t                     out_d
);

  bim_pkg::pipe_t mul_nxt, mul_r, acc_nxt, acc_r;
  logic           mul_v_r, acc_v_r;

  // coordinate times stride, remainder cleared for the next axis
  always_comb begin
    mul_nxt        = in_d;
    mul_nxt.prod_l = in_d.rem * step_l;
    mul_nxt.prod_r = in_d.rem * step_r;
    mul_nxt.rem    = '0;
  end

  always_comb begin
    acc_nxt       = mul_r;
    acc_nxt.acc_l = mul_r.acc_l + bim_pkg::OFF_BITS'(mul_r.prod_l);
    acc_nxt.acc_r = mul_r.acc_r + bim_pkg::OFF_BITS'(mul_r.prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      acc_v_r <= 1'b0;
    end else if (adv) begin
      mul_v_r <= in_v;
      acc_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r <= mul_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign out_v = acc_v_r;
  assign out_d = acc_r;

endmodule
`default_nettype wire

/* src/broadcast_index_mapper.sv */
`default_nettype none
// broadcast index mapper: turns a row-major flat index of a broadcast
// element-wise result into element offsets of the left and right operands
//
// channels
//   cfg_*  : register writes (index, data), always ready; write only while
//            no transaction is in flight
//   in_*   : stream of flat indexes, one per transaction
//   out_*  : one result per input transaction: offsets and status
//
// pipeline
//   one index per cycle sustained while out_tready does not stall the pipe.
//   each axis takes 8 divider stages (4 quotient bits each, 32-bit index)
//   plus a multiply stage and an accumulate stage
//
// reset clears the config registers (ranks 0, so the result is a single
// element) and the valid flags, which empties the pipe
//
// a stall on out_tready freezes the whole pipe and drops in_tready in the
// same cycle; nothing is lost or repeated
module broadcast_index_mapper (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [bim_pkg::REG_BITS-1:0]  cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // [31:0] flat_index
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [33:0] left_offset, [67:34] right_offset, [69:68] status, [71:70] zero
  output logic [71:0]                        out_tdata
);

  localparam int AXIS_NODES = bim_pkg::DIV_STAGES + 1;
  localparam int NODES      = bim_pkg::MAX_AXES * AXIS_NODES + 1;

  bim_pkg::shape_t shape;
  logic            adv;

  bim_pkg::pipe_t  node_d [NODES];
  logic            node_v [NODES];

  logic                          out_v_r;
  logic [bim_pkg::OFF_BITS-1:0]  left_r, right_r;
  bim_pkg::status_t              status_r;
  bim_pkg::status_t              status_nxt;

  assign cfg_ready = 1'b1;

  bim_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .shape    (shape)
  );

  // whole pipe moves when the output slot is free or being drained
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    node_d[0]     = '0;
    node_d[0].quo = in_tdata[bim_pkg::IDX_BITS-1:0];
    node_v[0]     = in_tvalid;
  end

  for (genvar a = 0; a < bim_pkg::MAX_AXES; a++) begin : g_axis
    for (genvar j = 0; j < bim_pkg::DIV_STAGES; j++) begin : g_div
      bim_div_stage u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (node_v[a*AXIS_NODES+j]),
        .in_d    (node_d[a*AXIS_NODES+j]),
        .divisor (shape.divisor[a]),
        .out_v   (node_v[a*AXIS_NODES+j+1]),
        .out_d   (node_d[a*AXIS_NODES+j+1])
      );
    end
    bim_mac_stage u_mac (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .in_v   (node_v[a*AXIS_NODES+bim_pkg::DIV_STAGES]),
      .in_d   (node_d[a*AXIS_NODES+bim_pkg::DIV_STAGES]),
      .step_l (shape.step_l[a]),
      .step_r (shape.step_r[a]),
      .out_v  (node_v[(a+1)*AXIS_NODES]),
      .out_d  (node_d[(a+1)*AXIS_NODES])
    );
  end

  // shape errors win over range errors; leftover quotient means index too big
  always_comb begin
    if (shape.bad) begin
      status_nxt = bim_pkg::ST_SHAPE;
    end else if (shape.empty || node_d[NODES-1].quo != '0) begin
      status_nxt = bim_pkg::ST_RANGE;
    end else begin
      status_nxt = bim_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= node_v[NODES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      left_r   <= (status_nxt == bim_pkg::ST_OK) ? node_d[NODES-1].acc_l : '0;
      right_r  <= (status_nxt == bim_pkg::ST_OK) ? node_d[NODES-1].acc_r : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, status_r, right_r, left_r};

endmodule
`default_nettype wire
